// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the escaper modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    `ASSERT_PROP(label, clk, rst_n, !(cond))

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== hdl/xce_pkg.sv =====
// Types and constants of the XML character escaper.
`timescale 1ns / 1ps

package xce_pkg;

    localparam int RUN_MAX = 6;
    localparam int LEN_W   = 3;
    localparam int IDX_W   = 3;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'd126;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       run_end;
        logic       string_end;
    } result_t;

    // One escaped run: bytes[0] goes out first.
    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [LEN_W-1:0]        len;
        logic                    last;
    } run_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_EMIT
    } back_state_t;

endpackage

// ===== hdl/xce_front.sv =====
// Front end: accept a byte, build its escaped run and hold it for the queue.
`timescale 1ns / 1ps

module xce_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  xce_pkg::item_t  item,
    output logic            busy,
    input  logic            q_full,
    output logic            push,
    output xce_pkg::run_t   push_run
);

    logic            stage_valid_reg;
    logic            stage_valid_next;
    xce_pkg::run_t   stage_run_reg;
    xce_pkg::run_t   run_c;
    logic            accept;

    logic [7:0]      c;
    logic [1:0]      hund;
    logic [7:0]      hund_x100;
    logic [6:0]      rem;
    logic [14:0]     tens_prod;
    logic [3:0]      tens;
    logic [3:0]      ones;

    // Plain bytes pass as themselves; every escape opens with an ampersand.
    function automatic logic [7:0] CH_AMP_OR(input logic [7:0] ch);
        logic plain;
        plain = (ch >= xce_pkg::CH_SPACE) && (ch <= xce_pkg::CH_TILDE)
             && (ch != xce_pkg::CH_LT) && (ch != xce_pkg::CH_GT)
             && (ch != xce_pkg::CH_AMP) && (ch != xce_pkg::CH_APOS)
             && (ch != xce_pkg::CH_QUOT);
        return plain ? ch : xce_pkg::CH_AMP;
    endfunction

    assign busy   = stage_valid_reg && q_full;
    assign accept = start && !busy;
    assign push   = stage_valid_reg && !q_full;
    assign push_run = stage_run_reg;

    // Split the byte into decimal digits: hundreds by compare, tens by reciprocal.
    always_comb
    begin
        c = item.char_in;
        if (c >= 8'd200)
        begin
            hund      = 2'd2;
            hund_x100 = 8'd200;
        end
        else if (c >= 8'd100)
        begin
            hund      = 2'd1;
            hund_x100 = 8'd100;
        end
        else
        begin
            hund      = 2'd0;
            hund_x100 = 8'd0;
        end
        rem       = 7'(c - hund_x100);
        tens_prod = 15'(rem) * 15'd205;
        tens      = 4'(tens_prod >> 11);
        ones      = 4'(rem - 7'(tens) * 7'd10);
    end

    always_comb
    begin
        run_c       = '0;
        run_c.last  = item.last_in;
        run_c.bytes[0] = CH_AMP_OR(c);
        case (c)
            xce_pkg::CH_LT:
            begin
                run_c.bytes[1] = "l";
                run_c.bytes[2] = "t";
                run_c.bytes[3] = xce_pkg::CH_SEMI;
                run_c.len      = 3'd4;
            end
            xce_pkg::CH_GT:
            begin
                run_c.bytes[1] = "g";
                run_c.bytes[2] = "t";
                run_c.bytes[3] = xce_pkg::CH_SEMI;
                run_c.len      = 3'd4;
            end
            xce_pkg::CH_AMP:
            begin
                run_c.bytes[1] = "a";
                run_c.bytes[2] = "m";
                run_c.bytes[3] = "p";
                run_c.bytes[4] = xce_pkg::CH_SEMI;
                run_c.len      = 3'd5;
            end
            xce_pkg::CH_APOS:
            begin
                run_c.bytes[1] = "a";
                run_c.bytes[2] = "p";
                run_c.bytes[3] = "o";
                run_c.bytes[4] = "s";
                run_c.bytes[5] = xce_pkg::CH_SEMI;
                run_c.len      = 3'd6;
            end
            xce_pkg::CH_QUOT:
            begin
                run_c.bytes[1] = "q";
                run_c.bytes[2] = "u";
                run_c.bytes[3] = "o";
                run_c.bytes[4] = "t";
                run_c.bytes[5] = xce_pkg::CH_SEMI;
                run_c.len      = 3'd6;
            end
            default:
            begin
                if (c < xce_pkg::CH_SPACE || c > xce_pkg::CH_TILDE)
                begin
                    run_c.bytes[1] = xce_pkg::CH_HASH;
                    if (c >= 8'd100)
                    begin
                        run_c.bytes[2] = xce_pkg::CH_ZERO + {6'd0, hund};
                        run_c.bytes[3] = xce_pkg::CH_ZERO + {4'd0, tens};
                        run_c.bytes[4] = xce_pkg::CH_ZERO + {4'd0, ones};
                        run_c.bytes[5] = xce_pkg::CH_SEMI;
                        run_c.len      = 3'd6;
                    end
                    else if (c >= 8'd10)
                    begin
                        run_c.bytes[2] = xce_pkg::CH_ZERO + {4'd0, tens};
                        run_c.bytes[3] = xce_pkg::CH_ZERO + {4'd0, ones};
                        run_c.bytes[4] = xce_pkg::CH_SEMI;
                        run_c.len      = 3'd5;
                    end
                    else
                    begin
                        run_c.bytes[2] = xce_pkg::CH_ZERO + {4'd0, ones};
                        run_c.bytes[3] = xce_pkg::CH_SEMI;
                        run_c.len      = 3'd4;
                    end
                end
                else
                begin
                    run_c.len = 3'd1;
                end
            end
        endcase
    end

    always_comb
    begin
        if (accept)
            stage_valid_next = 1'b1;
        else if (push)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_run_reg <= run_c;
    end

endmodule

// ===== hdl/xce_queue.sv =====
// Short queue of escaped runs between front and back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xce_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  xce_pkg::run_t   push_run,
    input  logic            pop,
    output xce_pkg::run_t   head,
    output logic            empty,
    output logic            full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    xce_pkg::run_t          entries_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    assign head  = entries_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_FULL);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_run;
    end

    `ASSERT_NEVER(q_no_overflow, clk, rst_n, push && full)
    `ASSERT_NEVER(q_no_underflow, clk, rst_n, pop && empty)
    `ASSERT_PROP(q_count_bound, clk, rst_n, count_reg <= CNT_FULL)

endmodule

// ===== hdl/xce_back.sv =====
// Back end: play each queued run out one byte per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xce_back (
    input  logic              clk,
    input  logic              rst_n,
    input  xce_pkg::run_t     head,
    input  logic              q_empty,
    output logic              pop,
    output logic              strobe,
    output xce_pkg::result_t  result
);

    xce_pkg::back_state_t           state_reg;
    xce_pkg::back_state_t           state_next;
    xce_pkg::run_t                  run_reg;
    xce_pkg::run_t                  run_next;
    logic [xce_pkg::IDX_W-1:0]      idx_reg;
    logic [xce_pkg::IDX_W-1:0]      idx_next;
    logic                           strobe_reg;
    logic                           strobe_next;
    xce_pkg::result_t               result_reg;
    xce_pkg::result_t               result_next;
    logic                           at_end;

    assign at_end = (idx_reg == run_reg.len - 1'b1);
    assign strobe = strobe_reg;
    assign result = result_reg;

    always_comb
    begin
        case (state_reg)
            xce_pkg::BACK_IDLE:
                state_next = q_empty ? xce_pkg::BACK_IDLE : xce_pkg::BACK_EMIT;
            xce_pkg::BACK_EMIT:
                state_next = (at_end && q_empty) ? xce_pkg::BACK_IDLE : xce_pkg::BACK_EMIT;
            default:
                state_next = xce_pkg::BACK_IDLE;
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        strobe_next = 1'b0;
        run_next    = run_reg;
        idx_next    = idx_reg;
        result_next.char_out   = run_reg.bytes[idx_reg];
        result_next.run_end    = at_end;
        result_next.string_end = at_end && run_reg.last;
        case (state_reg)
            xce_pkg::BACK_IDLE:
            begin
                pop = !q_empty;
            end
            xce_pkg::BACK_EMIT:
            begin
                strobe_next = 1'b1;
                pop         = at_end && !q_empty;
                idx_next    = idx_reg + 1'b1;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
        // Load the next run as soon as the current one drains.
        if (pop)
        begin
            run_next = head;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= xce_pkg::BACK_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg    <= run_next;
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    `ASSERT_PROP(b_idx_in_run, clk, rst_n, (state_reg == xce_pkg::BACK_EMIT) |-> (idx_reg < run_reg.len))
    `ASSERT_PROP(b_strobe_follows_emit, clk, rst_n, (state_reg == xce_pkg::BACK_EMIT) |=> strobe_reg)
    `ASSERT_PROP(b_string_end_closes_run, clk, rst_n, (strobe_reg && result_reg.string_end) |-> result_reg.run_end)

endmodule

// ===== hdl/xml_character_escaper.sv =====
// Top level of the XML character escaper.
`timescale 1ns / 1ps
//
//  Channel   Ports                 Beat taken when
//  -------   -------------------   --------------------------------------
//  input     start, busy, item     rising edge with start high, busy low
//  output    strobe, result        every edge that ends a strobe cycle
//
//  A byte enters the front stage register and its escaped run waits
//  in a QUEUE_DEPTH-entry queue. While runs are queued, the back end
//  plays out one output byte per cycle: a plain byte gives one output
//  byte, an escaped byte four to six.
//  The output rate is set by the back end's byte sequencer; busy rises
//  only when the front stage holds a run and the queue is full.
//  Reset clears the stage, queue pointers and back end state at once.
//  The receiver cannot stall: each output beat is shown for one cycle.

module xml_character_escaper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  xce_pkg::item_t    item,
    output logic              busy,
    output logic              strobe,
    output xce_pkg::result_t  result
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    xce_pkg::run_t   q_in_run;
    xce_pkg::run_t   q_head;

    // Classify the byte and build its run.
    xce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .busy     (busy),
        .q_full   (q_full),
        .push     (q_push),
        .push_run (q_in_run)
    );

    // Decouple front and back so each can stall on its own.
    xce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_run (q_in_run),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Drain runs byte by byte onto the registered result port.
    xce_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .pop     (q_pop),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the XML character escaper.
`timescale 1ns / 1ps

// Tracks the escaped runs owed by the block and checks each output beat.
class escape_scoreboard;
    xce_pkg::result_t pending[$];
    int               mismatches;
    int               beats_checked;
    int               bytes_taken;
    int               strings_taken;
    int               escaped_taken;

    // Expand one source byte into the output beats it must produce.
    function void note_byte(xce_pkg::item_t it);
        logic [7:0]       run_bytes[$];
        logic [7:0]       c;
        xce_pkg::result_t beat;
        c = it.char_in;
        case (c)
            xce_pkg::CH_LT:
                run_bytes = '{xce_pkg::CH_AMP, "l", "t", xce_pkg::CH_SEMI};
            xce_pkg::CH_GT:
                run_bytes = '{xce_pkg::CH_AMP, "g", "t", xce_pkg::CH_SEMI};
            xce_pkg::CH_AMP:
                run_bytes = '{xce_pkg::CH_AMP, "a", "m", "p", xce_pkg::CH_SEMI};
            xce_pkg::CH_APOS:
                run_bytes = '{xce_pkg::CH_AMP, "a", "p", "o", "s", xce_pkg::CH_SEMI};
            xce_pkg::CH_QUOT:
                run_bytes = '{xce_pkg::CH_AMP, "q", "u", "o", "t", xce_pkg::CH_SEMI};
            default:
            begin
                if (c < xce_pkg::CH_SPACE || c > xce_pkg::CH_TILDE)
                begin
                    run_bytes.push_back(xce_pkg::CH_AMP);
                    run_bytes.push_back(xce_pkg::CH_HASH);
                    if (c >= 8'd100)
                        run_bytes.push_back(xce_pkg::CH_ZERO + c / 8'd100);
                    if (c >= 8'd10)
                        run_bytes.push_back(xce_pkg::CH_ZERO + (c / 8'd10) % 8'd10);
                    run_bytes.push_back(xce_pkg::CH_ZERO + c % 8'd10);
                    run_bytes.push_back(xce_pkg::CH_SEMI);
                end
                else
                    run_bytes.push_back(c);
            end
        endcase
        for (int k = 0; k < run_bytes.size(); k++)
        begin
            beat.char_out   = run_bytes[k];
            beat.run_end    = (k == run_bytes.size() - 1);
            beat.string_end = beat.run_end & it.last_in;
            pending.push_back(beat);
        end
        bytes_taken++;
        if (it.last_in)
            strings_taken++;
        if (run_bytes.size() > 1)
            escaped_taken++;
    endfunction

    // Compare one output beat against the oldest owed beat.
    function void check_beat(xce_pkg::result_t got);
        xce_pkg::result_t want;
        if (pending.size() == 0)
        begin
            $error("output beat char_out 0x%02h with no beat owed", got.char_out);
            mismatches++;
            return;
        end
        want = pending.pop_front();
        beats_checked++;
        if (got.char_out !== want.char_out)
        begin
            $error("char_out: expected 0x%02h, got 0x%02h", want.char_out, got.char_out);
            mismatches++;
        end
        if (got.run_end !== want.run_end)
        begin
            $error("run_end: expected %b, got %b", want.run_end, got.run_end);
            mismatches++;
        end
        if (got.string_end !== want.string_end)
        begin
            $error("string_end: expected %b, got %b", want.string_end, got.string_end);
            mismatches++;
        end
    endfunction
endclass

module testbench;

    // Generous bound: far above the run time even with every byte escaped
    // to six beats plus the sender gaps.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_BYTES = 420;

    logic             clk;
    logic             rst_n;
    logic             start;
    xce_pkg::item_t   item;
    logic             busy;
    logic             strobe;
    xce_pkg::result_t result;

    escape_scoreboard sb;
    int unsigned      cycle_count = 0;

    xml_character_escaper dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost beat ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Monitors sample at the rising edge, before the block's own updates
    // land, so they see the values that the edge actually takes.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_byte(item);
    end

    // The receiver never stalls: every strobe cycle is one output beat.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_beat(result);
    end

    // Present one input beat from a falling edge and hold it until taken.
    // Returns at the falling edge after the acceptance edge, with start
    // still high so a back-to-back beat needs no drop in between.
    task automatic send_byte(input logic [7:0] c, input logic last);
        start        <= 1'b1;
        item.char_in <= c;
        item.last_in <= last;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Drop start for single cycles, each idle with the given chance in percent.
    task automatic maybe_idle(input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start        <= 1'b0;
            item.char_in <= 8'($urandom);
            item.last_in <= 1'($urandom);
            @(negedge clk);
        end
    endtask

    // Draw a byte, weighted toward the escaping classes.
    function automatic logic [7:0] pick_char();
        logic [7:0] markup[5];
        markup = '{xce_pkg::CH_LT, xce_pkg::CH_GT, xce_pkg::CH_AMP,
                   xce_pkg::CH_APOS, xce_pkg::CH_QUOT};
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'($urandom_range(32, 126));
            4, 5:       return markup[$urandom_range(4)];
            6, 7:       return 8'($urandom_range(0, 31));
            default:    return 8'($urandom_range(127, 255));
        endcase
    endfunction

    initial
    begin
        logic [7:0] edge_chars[$];
        int         idle_pct[3];
        int         sent;
        int         str_len;
        sb          = new();
        rst_n       = 1'b0;
        start       = 1'b0;
        item        = '0;
        // Phases: back to back, sender mostly idle, sender lightly idle.
        idle_pct    = '{0, 67, 18};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: the zero byte, both ends of each escaping class, the
        // digit-count boundaries, every markup character and plain text.
        edge_chars = '{8'd0, 8'd1, 8'd9, 8'd10, 8'd31, xce_pkg::CH_SPACE, 8'h21,
                       xce_pkg::CH_QUOT, xce_pkg::CH_AMP, xce_pkg::CH_APOS,
                       xce_pkg::CH_LT, xce_pkg::CH_GT, 8'h41, 8'h7A,
                       xce_pkg::CH_TILDE, 8'd127, 8'd99, 8'd100, 8'd199, 8'd200,
                       8'd255};
        foreach (edge_chars[i])
            send_byte(edge_chars[i], (i % 4) == 3 || i == edge_chars.size() - 1);

        // Random: mostly well-formed strings, with a sprinkle of stray
        // string-end marks as noise.
        for (int ph = 0; ph < 3; ph++)
        begin
            sent = 0;
            while (sent < RANDOM_BYTES / 3)
            begin
                str_len = $urandom_range(1, 12);
                for (int k = 0; k < str_len; k++)
                begin
                    if ($urandom_range(19) == 0)
                        send_byte(pick_char(), 1'($urandom));
                    else
                        send_byte(pick_char(), k == str_len - 1);
                    sent++;
                    maybe_idle(idle_pct[ph]);
                end
            end
        end
        start <= 1'b0;

        // Drain the owed beats, then hold a while to catch strays.
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Took %0d source bytes in %0d strings, %0d of them escaped.",
                 sb.bytes_taken, sb.strings_taken, sb.escaped_taken);
        $display("Checked %0d output beats across three sender idle phases.",
                 sb.beats_checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/xce_pkg.sv
hdl/xce_front.sv
hdl/xce_queue.sv
hdl/xce_back.sv
hdl/xml_character_escaper.sv
test/testbench.sv
